@@ hw/rtl/bitmap_run_allocator_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Bitmap run allocator assertion macros
// Shorthand for the concurrent checks used by the allocator modules.
// ----------------------------------------------------------------------------
`ifndef BITMAP_RUN_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_RUN_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bitmap run allocator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BRA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bitmap run allocator check failed");

`endif

@@ hw/rtl/bra_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap run allocator package
// Shared constants, operation and status codes, and interface structs.
// ----------------------------------------------------------------------------
package bra_pkg;

	// Map storage in bytes, and the most bytes a 12-bit bit index can reach.
	localparam int MAP_BYTES   = 512;
	localparam int INDEX_BYTES = 512;
	localparam int LIVE_BYTES  = (MAP_BYTES < INDEX_BYTES) ? MAP_BYTES : INDEX_BYTES;

	localparam int MAP_AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int CFG_W  = 10;
	localparam int IDX_W  = 12;
	localparam int RUN_W  = 13;
	localparam int PTR_W  = ($clog2(MAP_BYTES + 1) > CFG_W) ? $clog2(MAP_BYTES + 1) : CFG_W;
	localparam int SUM_W  = PTR_W + 3;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(512);

	localparam logic [1:0] OP_TEST  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_SCAN  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_RUN  = 2'd1;
	localparam logic [1:0] ST_OUTSIDE = 2'd2;

	// Outcome of evaluating one map byte against the running free count.
	typedef struct packed {
		logic             found;
		logic [2:0]       pos;
		logic [RUN_W-1:0] run;
	} scan_res_t;

	// One result word handed from the sequencer to the output register.
	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] start_index;
		logic [1:0]       status;
	} result_t;

endpackage

@@ hw/rtl/bra_map_ram.sv @@
// ----------------------------------------------------------------------------
// Bitmap run allocator map memory
// Simple dual-port RAM: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bra_map_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 8,
	parameter int AW    = 9
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/bra_run_scan.sv @@
// ----------------------------------------------------------------------------
// Bitmap run allocator byte scanner
// Extends the running free-bit count across one map byte and finds the
// lowest bit at which the requested run length is reached.
// ----------------------------------------------------------------------------
module bra_run_scan (
	input  logic [7:0]              map_byte,
	input  logic [bra_pkg::RUN_W-1:0] run_in,
	input  logic [bra_pkg::RUN_W-1:0] need,
	output bra_pkg::scan_res_t      res
);

	logic [3:0]                loc   [8];
	logic [bra_pkg::RUN_W:0]   run_j [8];
	logic [7:0]                hit_j;

	always_comb begin
		// Zeros ending at each bit, counted inside this byte only.
		loc[0] = map_byte[0] ? 4'd0 : 4'd1;
		for (int j = 1; j < 8; j++) begin
			loc[j] = map_byte[j] ? 4'd0 : loc[j-1] + 4'd1;
		end
		// A bit whose lower byte bits are all free continues the carried run.
		for (int j = 0; j < 8; j++) begin
			run_j[j] = (bra_pkg::RUN_W+1)'(loc[j])
				+ ((loc[j] == 4'(j + 1)) ? (bra_pkg::RUN_W+1)'(run_in)
				                         : (bra_pkg::RUN_W+1)'(0));
			hit_j[j] = run_j[j] >= (bra_pkg::RUN_W+1)'(need);
		end
		res.found = |hit_j;
		res.pos   = 3'd0;
		for (int j = 7; j >= 0; j--) begin
			if (hit_j[j]) begin
				res.pos = 3'(j);
			end
		end
		res.run = bra_pkg::RUN_W'(run_j[7]);
	end

endmodule

@@ hw/rtl/bra_ctrl.sv @@
// ----------------------------------------------------------------------------
// Bitmap run allocator sequencer
// Runs the clearing pass, bit tests and writes, map clears and the
// byte-per-cycle first-fit scan over the map memory.
// ----------------------------------------------------------------------------
`include "bitmap_run_allocator_unit_macros.svh"

module bra_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [bra_pkg::CFG_W-1:0] cfg_bytes,
	input  logic                      req,
	input  logic [1:0]                opcode,
	input  logic [bra_pkg::IDX_W-1:0] bit_index,
	input  logic                      bit_value,
	input  logic [bra_pkg::RUN_W-1:0] run_length,
	output logic                      ready,
	output logic                      res_valid,
	input  logic                      res_ack,
	output bra_pkg::result_t          res
);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_TEVAL,
		S_SCAN,
		S_FOUND,
		S_CLEAR,
		S_RESP
	} state_t;

	state_t                         state_q;
	logic [bra_pkg::PTR_W-1:0]      ptr_q;
	logic [1:0]                     op_q;
	logic [2:0]                     bit_q;
	logic [bra_pkg::MAP_AW-1:0]     byte_q;
	logic                           val_q;
	logic [bra_pkg::RUN_W-1:0]      need_q;
	logic [bra_pkg::RUN_W-1:0]      run_q;
	logic                           rd_vld_s1;
	logic [bra_pkg::PTR_W-1:0]      rd_byte_s1;
	logic [2:0]                     fpos_q;
	logic [bra_pkg::PTR_W-1:0]      fbyte_q;
	bra_pkg::result_t               res_q;

	logic [bra_pkg::CFG_W-1:0]      nbytes;
	logic [bra_pkg::CFG_W+2:0]      nbits;
	logic                           outside;
	logic [1:0]                     req_status;
	logic                           ptr_lt;
	logic                           scan_last;
	logic                           scan_stop;
	logic [bra_pkg::SUM_W-1:0]      found_start;
	bra_pkg::scan_res_t             sres;

	logic                           mem_rd_en;
	logic [bra_pkg::MAP_AW-1:0]     mem_rd_addr;
	logic [7:0]                     mem_rd_data;
	logic                           mem_wr_en;
	logic [bra_pkg::MAP_AW-1:0]     mem_wr_addr;
	logic [7:0]                     mem_wr_data;
	logic [7:0]                     bit_mask;

	bra_map_ram #(
		.DEPTH (bra_pkg::MAP_BYTES),
		.WIDTH (8),
		.AW    (bra_pkg::MAP_AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	bra_run_scan u_scan (
		.map_byte (mem_rd_data),
		.run_in   (run_q),
		.need     (need_q),
		.res      (sres)
	);

	// The live map size saturates to what both the storage and the index reach.
	assign nbytes    = (cfg_bytes > bra_pkg::CFG_W'(bra_pkg::LIVE_BYTES))
		? bra_pkg::CFG_W'(bra_pkg::LIVE_BYTES) : cfg_bytes;
	assign nbits     = {nbytes, 3'b000};
	assign outside   = (bra_pkg::CFG_W+3)'(bit_index) >= nbits;
	assign ptr_lt    = ptr_q < bra_pkg::PTR_W'(nbytes);
	assign scan_last = rd_byte_s1 == (bra_pkg::PTR_W'(nbytes) - bra_pkg::PTR_W'(1));
	assign scan_stop = rd_vld_s1 && (sres.found || scan_last);
	assign bit_mask  = 8'd1 << bit_q;

	// Status known at acceptance: an access outside the map, or a scan of an
	// empty map. Everything else starts out as ok.
	assign req_status = ((opcode == bra_pkg::OP_TEST || opcode == bra_pkg::OP_WRITE) && outside)
		? bra_pkg::ST_OUTSIDE
		: ((opcode == bra_pkg::OP_SCAN && nbytes == '0) ? bra_pkg::ST_NO_RUN : bra_pkg::ST_OK);

	assign found_start = {fbyte_q, 3'b000} + bra_pkg::SUM_W'(fpos_q)
		+ bra_pkg::SUM_W'(1) - bra_pkg::SUM_W'(need_q);

	assign ready     = state_q == S_IDLE;
	assign res_valid = state_q == S_RESP;
	assign res       = res_q;

	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = bra_pkg::MAP_AW'(ptr_q);
		mem_wr_en   = 1'b0;
		mem_wr_addr = bra_pkg::MAP_AW'(ptr_q);
		mem_wr_data = 8'h00;
		unique case (state_q)
			S_INIT: begin
				mem_wr_en = 1'b1;
			end
			S_IDLE: begin
				if (req && (opcode == bra_pkg::OP_TEST || opcode == bra_pkg::OP_WRITE)
						&& !outside) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = bra_pkg::MAP_AW'(bit_index >> 3);
				end
			end
			S_TEVAL: begin
				if (op_q == bra_pkg::OP_WRITE) begin
					mem_wr_en   = 1'b1;
					mem_wr_addr = byte_q;
					mem_wr_data = val_q ? (mem_rd_data | bit_mask)
					                    : (mem_rd_data & ~bit_mask);
				end
			end
			S_SCAN: begin
				mem_rd_en = ptr_lt && !scan_stop;
			end
			S_CLEAR: begin
				mem_wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					if (ptr_q == bra_pkg::PTR_W'(bra_pkg::MAP_BYTES - 1)) begin
						ptr_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						ptr_q <= ptr_q + bra_pkg::PTR_W'(1);
					end
				end
				S_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (req) begin
						op_q   <= opcode;
						bit_q  <= bit_index[2:0];
						byte_q <= bra_pkg::MAP_AW'(bit_index >> 3);
						val_q  <= bit_value;
						need_q <= (run_length == '0) ? bra_pkg::RUN_W'(1) : run_length;
						run_q  <= '0;
						ptr_q  <= '0;
						res_q  <= '{hit: 1'b0, start_index: '0, status: req_status};
						case (opcode) inside
							bra_pkg::OP_TEST, bra_pkg::OP_WRITE: begin
								state_q <= outside ? S_RESP : S_TEVAL;
							end
							bra_pkg::OP_SCAN: begin
								state_q <= (nbytes == '0) ? S_RESP : S_SCAN;
							end
							default: begin
								state_q <= (nbytes == '0) ? S_RESP : S_CLEAR;
							end
						endcase
					end
				end
				S_TEVAL: begin
					if (op_q == bra_pkg::OP_TEST) begin
						res_q.hit <= mem_rd_data[bit_q];
					end
					state_q <= S_RESP;
				end
				S_SCAN: begin
					rd_vld_s1  <= mem_rd_en;
					rd_byte_s1 <= ptr_q;
					if (mem_rd_en) begin
						ptr_q <= ptr_q + bra_pkg::PTR_W'(1);
					end
					if (rd_vld_s1) begin
						if (sres.found) begin
							fpos_q  <= sres.pos;
							fbyte_q <= rd_byte_s1;
							state_q <= S_FOUND;
						end else begin
							run_q <= sres.run;
							if (scan_last) begin
								res_q.status <= bra_pkg::ST_NO_RUN;
								state_q      <= S_RESP;
							end
						end
					end
				end
				S_FOUND: begin
					res_q.hit         <= 1'b1;
					res_q.start_index <= found_start[bra_pkg::IDX_W-1:0];
					state_q           <= S_RESP;
				end
				S_CLEAR: begin
					ptr_q <= ptr_q + bra_pkg::PTR_W'(1);
					if (ptr_q == bra_pkg::PTR_W'(nbytes) - bra_pkg::PTR_W'(1)) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (res_ack) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`BRA_ASSERT_IMP(a_scan_read_in_map, clk, arst_n, mem_rd_en && state_q == S_SCAN, ptr_lt)
	`BRA_ASSERT_IMP(a_clear_write_in_map, clk, arst_n, state_q == S_CLEAR, ptr_lt)
	`BRA_ASSERT_IMP(a_outside_no_hit, clk, arst_n, res_valid && res_q.status == bra_pkg::ST_OUTSIDE, !res_q.hit && res_q.start_index == '0)
	`BRA_ASSERT_NXT(a_req_leaves_idle, clk, arst_n, req && ready, state_q != S_IDLE)
	`BRA_ASSERT_IMP(a_found_is_ok, clk, arst_n, res_valid && res_q.hit && op_q == bra_pkg::OP_SCAN, res_q.status == bra_pkg::ST_OK)

endmodule

@@ hw/rtl/bitmap_run_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// Bitmap run allocator
// First-fit allocator over a 4096-bit occupancy map with bit test, bit
// write, free-run scan and map clear operations.
// ----------------------------------------------------------------------------
// Usage: a request word (opcode, bit_index, bit_value, run_length) is taken
// when in_valid is high and in_stall is low. Every request yields exactly one
// result word (hit, start_index, status), offered on out_valid and taken when
// out_stall is low. cfg_wr_en writes cfg_wr_data into the bytes-in-use register;
// the user must do so only while no request is outstanding; nothing enforces it.
// Sequence: a test or write reads its map byte, evaluates it (a write stores
// the updated byte back) and then offers its result; an index outside the
// map answers without reading. A clear writes zero to each byte in use in
// turn. A scan reads one map byte per cycle through the single map memory
// read port; a run found in a byte first has its start index computed before
// the result is offered, and a scan that finds none answers after the last
// byte in use. One request is worked on at a time; in_stall stays high until
// the result has moved into the output register.
// Reset: the bytes-in-use register returns to 512 and the sequencer sweeps
// all 512 map bytes to zero, one byte per cycle, holding in_stall high until
// the sweep ends. Configuration writes are taken during the sweep.
// Stalls: while out_stall holds a result in the output register, the block
// can still accept and process the next request; that result waits in the
// sequencer until the output register frees.
// ----------------------------------------------------------------------------
module bitmap_run_allocator_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [bra_pkg::CFG_W-1:0] cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                opcode,
	input  logic [bra_pkg::IDX_W-1:0] bit_index,
	input  logic                      bit_value,
	input  logic [bra_pkg::RUN_W-1:0] run_length,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      hit,
	output logic [bra_pkg::IDX_W-1:0] start_index,
	output logic [1:0]                status
);

	logic [bra_pkg::CFG_W-1:0] cfg_bytes_q;
	logic                      out_valid_q;
	bra_pkg::result_t          out_q;

	logic                      ready;
	logic                      req;
	logic                      res_valid;
	logic                      res_ack;
	bra_pkg::result_t          res;

	// The sequencer only takes a word while it is idle.
	assign in_stall = !ready;
	assign req      = in_valid && ready;

	// The output register frees when it is empty or being drained this cycle.
	assign res_ack  = res_valid && (!out_valid_q || !out_stall);

	bra_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_bytes  (cfg_bytes_q),
		.req        (req),
		.opcode     (opcode),
		.bit_index  (bit_index),
		.bit_value  (bit_value),
		.run_length (run_length),
		.ready      (ready),
		.res_valid  (res_valid),
		.res_ack    (res_ack),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_bytes_q <= bra_pkg::CFG_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cfg_bytes_q <= cfg_wr_data;
			end
			if (res_ack) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The result payload needs no reset; out_valid qualifies it.
	always_ff @(posedge clk) begin
		if (res_ack) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = out_q.hit;
	assign start_index = out_q.start_index;
	assign status      = out_q.status;

endmodule
